/* rtl/assert_macros.svh */
// Assertion macros shared by the deframer RTL.
// Included by rpd_out_queue.sv and radio_packet_deframer.sv; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RPD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define RPD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define RPD_ASSERT(lbl, clk, rst_n, prop)
`define RPD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/rpd_pkg.sv */
// Package for the radio packet deframer: constants, codes and the result record.
// Used by rpd_out_queue and radio_packet_deframer; depends on nothing.
`timescale 1ns / 1ps

package rpd_pkg;

	localparam int HEADER_BYTES = 5;
	localparam int COUNT_W      = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic REG_MAX_PAYLOAD_LEN = 1'b0;
	localparam logic REG_PAYLOAD_BUF_SIZE = 1'b1;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TOO_LARGE    = 3'd1,
		ST_TOO_SMALL    = 3'd2,
		ST_BAD_LENGTH   = 3'd3,
		ST_SHORT        = 3'd4,
		ST_LONG         = 3'd5,
		ST_BUFFER_SMALL = 3'd6
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] dev_id;
		logic [7:0] device_mode;
		logic [7:0] seq_id;
		logic [7:0] msg_class;
		logic [7:0] declared_length;
		status_t    status;
		logic [7:0] accepted_size;
		logic       last_result;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

/* rtl/rpd_out_queue.sv */
// Four-entry result queue: up to two results in per cycle, one out unless stalled.
// Depends on rpd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpd_out_queue
	import rpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_item
);

	result_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                pop;
	logic [QPTR_W-1:0]   wptr_nx1;

	assign out_valid = (cnt_q != '0);
	assign out_item  = ent_q[rptr_q];
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign wptr_nx1  = wptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			ent_q[wptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			ent_q[wptr_nx1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + QPTR_W'(push.count);
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	`RPD_NEVER(a_cnt_bound, clk, arst_n, cnt_q > QCNT_W'(QUEUE_DEPTH))
	`RPD_NEVER(a_push_when_full, clk, arst_n, (push.count != 2'd0) && !room)
	`RPD_ASSERT(a_pop_only, clk, arst_n, (pop && push.count == 2'd0) |=> (cnt_q == $past(cnt_q) - QCNT_W'(1)))

endmodule

/* rtl/radio_packet_deframer.sv */
// Top level of the radio packet deframer: header capture, length checks and output queue.
// Depends on rpd_pkg, rpd_out_queue and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The deframer takes one frame byte per cycle while in_stall is low. The byte count
// and header bytes are updated at the accepting edge, and the byte's results (a payload
// byte, a status record, or both when the last byte falls inside the payload) enter a
// four-entry result queue in that same edge, so a result can appear in the cycle after
// its byte. The output side delivers one result per cycle while out_stall is low; input
// is stalled while the queue holds three or more results.

module radio_packet_deframer
	import rpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic [7:0] dev_id,
	output logic [7:0] device_mode,
	output logic [7:0] seq_id,
	output logic [7:0] msg_class,
	output logic [7:0] declared_length,
	output logic [2:0] status,
	output logic [7:0] accepted_size,
	output logic       last_result
);

	logic [7:0]         max_len_q;
	logic [7:0]         buf_size_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [7:0]         hdr_q [HEADER_BYTES];
	logic [7:0]         hdr_nx [HEADER_BYTES];

	logic               in_acc;
	logic               room;
	logic               in_hdr;
	logic [COUNT_W-1:0] pay_off;
	logic               pay_hit;
	logic [COUNT_W-1:0] cnt_inc;
	logic [COUNT_W:0]   size_w;
	logic [COUNT_W:0]   max_frame;
	logic [COUNT_W:0]   exp_frame;
	logic [7:0]         declared;
	status_t            st;
	result_t            r_pay;
	result_t            r_stat;
	push_t              push;
	result_t            out_item;

	assign in_stall = !room;
	assign in_acc   = in_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q  <= 8'hFF;
			buf_size_q <= 8'hFF;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_PAYLOAD_LEN:  max_len_q  <= cfg_wr_data;
				REG_PAYLOAD_BUF_SIZE: buf_size_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign in_hdr  = (cnt_q < COUNT_W'(HEADER_BYTES));
	assign pay_off = cnt_q - COUNT_W'(HEADER_BYTES);
	assign pay_hit = !in_hdr && (pay_off < {1'b0, hdr_q[HEADER_BYTES-1]});
	assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);

	always_comb begin
		for (int i = 0; i < HEADER_BYTES; i++) begin
			hdr_nx[i] = (in_hdr && cnt_q == COUNT_W'(i)) ? data_byte : hdr_q[i];
		end
	end

	assign declared  = hdr_nx[HEADER_BYTES-1];
	assign size_w    = {1'b0, cnt_inc};
	assign max_frame = (COUNT_W+1)'(HEADER_BYTES) + (COUNT_W+1)'(max_len_q);
	assign exp_frame = (COUNT_W+1)'(HEADER_BYTES) + (COUNT_W+1)'(declared);

	always_comb begin
		priority if (size_w > max_frame) begin
			st = ST_TOO_LARGE;
		end else if (size_w < (COUNT_W+1)'(HEADER_BYTES)) begin
			st = ST_TOO_SMALL;
		end else if (declared > max_len_q) begin
			st = ST_BAD_LENGTH;
		end else if (size_w < exp_frame) begin
			st = ST_SHORT;
		end else if (size_w > exp_frame) begin
			st = ST_LONG;
		end else if (declared != 8'd0 && buf_size_q < declared) begin
			st = ST_BUFFER_SMALL;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		r_pay.kind            = KIND_PAYLOAD;
		r_pay.payload_byte    = data_byte;
		r_pay.payload_index   = pay_off[7:0];
		r_pay.dev_id          = hdr_nx[0];
		r_pay.device_mode     = hdr_nx[1];
		r_pay.seq_id          = hdr_nx[2];
		r_pay.msg_class       = hdr_nx[3];
		r_pay.declared_length = hdr_nx[4];
		r_pay.status          = ST_OK;
		r_pay.accepted_size   = 8'd0;
		r_pay.last_result     = !last_byte;

		r_stat                = r_pay;
		r_stat.kind           = KIND_STATUS;
		r_stat.payload_byte   = 8'd0;
		r_stat.payload_index  = 8'd0;
		r_stat.status         = st;
		r_stat.accepted_size  = (st == ST_OK) ? declared : 8'd0;
		r_stat.last_result    = 1'b1;
	end

	always_comb begin
		push.first  = r_pay;
		push.second = r_stat;
		if (!in_acc) begin
			push.count = 2'd0;
		end else if (pay_hit && last_byte) begin
			push.count = 2'd2;
		end else if (pay_hit) begin
			push.count = 2'd1;
		end else if (last_byte) begin
			push.count = 2'd1;
			push.first = r_stat;
		end else begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < HEADER_BYTES; i++) begin
				hdr_q[i] <= 8'd0;
			end
		end else if (in_acc) begin
			if (last_byte) begin
				cnt_q <= '0;
				for (int i = 0; i < HEADER_BYTES; i++) begin
					hdr_q[i] <= 8'd0;
				end
			end else begin
				cnt_q <= cnt_inc;
				for (int i = 0; i < HEADER_BYTES; i++) begin
					hdr_q[i] <= hdr_nx[i];
				end
			end
		end
	end

	rpd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign kind            = out_item.kind;
	assign payload_byte    = out_item.payload_byte;
	assign payload_index   = out_item.payload_index;
	assign dev_id          = out_item.dev_id;
	assign device_mode     = out_item.device_mode;
	assign seq_id          = out_item.seq_id;
	assign msg_class       = out_item.msg_class;
	assign declared_length = out_item.declared_length;
	assign status          = out_item.status;
	assign accepted_size   = out_item.accepted_size;
	assign last_result     = out_item.last_result;

	`RPD_ASSERT(a_frame_end_clears, clk, arst_n, (in_acc && last_byte) |=> (cnt_q == '0 && hdr_q[HEADER_BYTES-1] == 8'd0))
	`RPD_NEVER(a_two_only_on_last, clk, arst_n, (push.count == 2'd2) && !last_byte)
	`RPD_NEVER(a_payload_in_header, clk, arst_n, pay_hit && in_hdr)

endmodule
